FILE: src/qvr_pkg.sv
// quaternion vector rotate: shared types and constants
// used by every module of the rotate core
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;
   localparam int DW          = 32;    // field width
   localparam int QUEUE_DEPTH = 4;     // front to back queue entries
   localparam int PW          = 2*DW;  // quaternion part product
   localparam int CW          = PW+2;  // rotation coefficient / norm
   localparam int NW          = 100;   // numerator, signed
   localparam int RW          = 102;   // divider remainder
   localparam int QB          = 35;    // quotient bits
   localparam int SPLIT       = 33;    // coefficient split point

   typedef logic [2:0][DW-1:0] vec_type;
   typedef logic [3:0][DW-1:0] quat_type;

   typedef struct packed {
      logic     zero;
      quat_type quat;
      vec_type  vec;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;
endpackage
`default_nettype wire

FILE: src/quaternion_vector_rotate_core.sv
// path from req transaction to rsp_tvalid: input register, queue, six arithmetic stages,
// 35 divide stages, output register
// throughput: one transaction per cycle while the rsp side does not stall, set by the fully pipelined restoring divider
// a stalled rsp side holds the whole back pipeline; the queue keeps accepting until full
// reset: synchronous, active high, clears all valid bits and queue pointers
`timescale 1ns / 1ps
`default_nettype none
module quaternion_vector_rotate_core
   import qvr_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
)(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
   input  wire logic [7*DW-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   // rot_x, rot_y, rot_z
   output logic [3*DW-1:0]      rsp_tdata,
   // zero_length, saturated
   output logic [1:0]           rsp_tuser
);
   qstat_type q_stat;
   logic      push, pop;
   item_type  push_item, head;

   qvr_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_stat, .push, .push_item
   );

   qvr_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock, .reset, .push, .push_item, .pop, .head, .q_stat
   );

   qvr_back u_back (
      .clock, .reset, .head, .q_stat, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );
endmodule
`default_nettype wire

FILE: src/qvr_front.sv
// quaternion vector rotate: input register and zero-length classification
// depends on qvr_pkg
`timescale 1ns / 1ps
`default_nettype none
module qvr_front
   import qvr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7*DW-1:0] req_tdata,
   input  wire qstat_type     q_stat,
   output logic               push,
   output item_type           push_item
);
   logic     front_v_ff, front_v_in;
   item_type front_ff, front_in;
   logic     take;

   assign push       = front_v_ff & ~q_stat.full;
   assign req_tready = ~front_v_ff | ~q_stat.full;
   assign take       = req_tvalid & req_tready;
   assign front_v_in = take | (front_v_ff & ~push);
   assign push_item  = front_ff;

   always_comb begin
      front_in.quat = quat_type'(req_tdata[4*DW-1:0]);
      front_in.vec  = vec_type'(req_tdata[7*DW-1:4*DW]);
      front_in.zero = (req_tdata[4*DW-1:0] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else begin
         front_v_ff <= front_v_in;
      end
      if (take) begin
         front_ff <= front_in;
      end
   end
endmodule
`default_nettype wire

FILE: src/qvr_queue.sv
// quaternion vector rotate: short queue between front and back
// depends on qvr_pkg
`timescale 1ns / 1ps
`default_nettype none
module qvr_queue
   import qvr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      head,
   output qstat_type     q_stat
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH+1);

   item_type        mem_ff [0:DEPTH-1];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   assign head         = mem_ff[rd_ff];
   assign q_stat.full  = (cnt_ff == CNTW'(DEPTH));
   assign q_stat.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

FILE: src/qvr_back.sv
// quaternion vector rotate: arithmetic pipeline, products, coefficients,
// pipelined restoring divide, rounding and saturation; depends on qvr_pkg
`timescale 1ns / 1ps
`default_nettype none
module qvr_back
   import qvr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire item_type  head,
   input  wire qstat_type q_stat,
   output logic           pop,
   output logic           rsp_tvalid,
   input  wire logic      rsp_tready,
   output logic [3*DW-1:0] rsp_tdata,
   output logic [1:0]     rsp_tuser
);
   logic adv;

   // stage 1: quaternion part products
   logic                 s1_v_ff, s1_z_ff;
   vec_type              s1_vec_ff;
   logic signed [PW-1:0] s1_p_ff [0:9];
   // stage 2: rotation coefficients and squared norm
   logic                 s2_v_ff, s2_z_ff;
   vec_type              s2_vec_ff;
   logic signed [CW-1:0] s2_c_ff [0:8];
   logic [CW-1:0]        s2_d_ff;
   // stage 3: split partial products
   logic                    s3_v_ff, s3_z_ff;
   vec_type                 s3_vec_ff;
   logic signed [CW-1:0]    s3_lo_ff [0:8];
   logic signed [CW-2:0]    s3_hi_ff [0:8];
   logic [CW-1:0]           s3_d_ff;
   // stage 4: full products
   logic                 s4_v_ff, s4_z_ff;
   vec_type              s4_vec_ff;
   logic signed [NW-1:0] s4_p_ff [0:8];
   logic [CW-1:0]        s4_d_ff;
   // stage 5: numerators
   logic                 s5_v_ff, s5_z_ff;
   vec_type              s5_vec_ff;
   logic signed [NW-1:0] s5_n_ff [0:2];
   logic [CW-1:0]        s5_d_ff;
   // divider, index 0 is the set-up stage
   logic          dv_v_ff   [0:QB];
   logic          dv_z_ff   [0:QB];
   vec_type       dv_vec_ff [0:QB];
   logic [CW-1:0] dv_d_ff   [0:QB];
   logic [RW-1:0] dv_rem_ff [0:QB][0:2];
   logic [QB-1:0] dv_q_ff   [0:QB][0:2];
   logic          dv_neg_ff [0:QB][0:2];
   logic [RW-1:0] dv_rem_in [1:QB][0:2];
   logic [QB-1:0] dv_q_in   [1:QB][0:2];
   logic [RW-1:0] su_rem_in [0:2];
   // output register
   logic            out_v_ff;
   logic [3*DW-1:0] out_data_ff, out_data_in;
   logic [1:0]      out_user_ff, out_user_in;

   assign adv        = ~out_v_ff | rsp_tready;
   assign pop        = adv & ~q_stat.empty;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // set-up of the divide: round half away from zero as (2|n| + d) / 2d
   always_comb begin
      logic [NW-1:0] mag;
      for (int r = 0; r < 3; r++) begin
         mag = s5_n_ff[r][NW-1] ? NW'(-s5_n_ff[r]) : NW'(s5_n_ff[r]);
         su_rem_in[r] = (RW'(mag) << 1) + RW'(s5_d_ff);
      end
   end

   // one quotient bit per stage
   always_comb begin
      logic [RW-1:0] den;
      for (int j = 1; j <= QB; j++) begin
         for (int r = 0; r < 3; r++) begin
            den = RW'(dv_d_ff[j-1]) << (QB+1-j);
            if (dv_rem_ff[j-1][r] >= den) begin
               dv_rem_in[j][r] = dv_rem_ff[j-1][r] - den;
               dv_q_in[j][r]   = {dv_q_ff[j-1][r][QB-2:0], 1'b1};
            end else begin
               dv_rem_in[j][r] = dv_rem_ff[j-1][r];
               dv_q_in[j][r]   = {dv_q_ff[j-1][r][QB-2:0], 1'b0};
            end
         end
      end
   end

   // saturate and assemble the result; a zero-length quaternion passes the input vector through
   always_comb begin
      logic [QB-1:0] q;
      logic          sat;
      logic [DW-1:0] res;
      sat = 1'b0;
      for (int r = 0; r < 3; r++) begin
         q = dv_q_ff[QB][r];
         if (dv_neg_ff[QB][r]) begin
            if (q > (QB'(1) << (DW-1))) begin
               res = {1'b1, {(DW-1){1'b0}}};
               sat = 1'b1;
            end else begin
               res = DW'(-q);
            end
         end else begin
            if (q > ((QB'(1) << (DW-1)) - QB'(1))) begin
               res = {1'b0, {(DW-1){1'b1}}};
               sat = 1'b1;
            end else begin
               res = q[DW-1:0];
            end
         end
         out_data_in[r*DW +: DW] = dv_z_ff[QB] ? dv_vec_ff[QB][r] : res;
      end
      out_user_in = {sat & ~dv_z_ff[QB], dv_z_ff[QB]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int j = 0; j <= QB; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         s1_v_ff    <= ~q_stat.empty;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         s4_v_ff    <= s3_v_ff;
         s5_v_ff    <= s4_v_ff;
         dv_v_ff[0] <= s5_v_ff;
         for (int j = 1; j <= QB; j++) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
         out_v_ff <= dv_v_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1
         s1_z_ff   <= head.zero;
         s1_vec_ff <= head.vec;
         s1_p_ff[0] <= $signed(head.quat[0]) * $signed(head.quat[0]);
         s1_p_ff[1] <= $signed(head.quat[1]) * $signed(head.quat[1]);
         s1_p_ff[2] <= $signed(head.quat[2]) * $signed(head.quat[2]);
         s1_p_ff[3] <= $signed(head.quat[3]) * $signed(head.quat[3]);
         s1_p_ff[4] <= $signed(head.quat[1]) * $signed(head.quat[2]);
         s1_p_ff[5] <= $signed(head.quat[0]) * $signed(head.quat[3]);
         s1_p_ff[6] <= $signed(head.quat[1]) * $signed(head.quat[3]);
         s1_p_ff[7] <= $signed(head.quat[0]) * $signed(head.quat[2]);
         s1_p_ff[8] <= $signed(head.quat[2]) * $signed(head.quat[3]);
         s1_p_ff[9] <= $signed(head.quat[0]) * $signed(head.quat[1]);
         // stage 2, order ww xx yy zz xy wz xz wy yz wx
         s2_z_ff   <= s1_z_ff;
         s2_vec_ff <= s1_vec_ff;
         s2_c_ff[0] <= CW'(s1_p_ff[0]) + CW'(s1_p_ff[1]) - CW'(s1_p_ff[2]) - CW'(s1_p_ff[3]);
         s2_c_ff[1] <= (CW'(s1_p_ff[4]) - CW'(s1_p_ff[5])) <<< 1;
         s2_c_ff[2] <= (CW'(s1_p_ff[6]) + CW'(s1_p_ff[7])) <<< 1;
         s2_c_ff[3] <= (CW'(s1_p_ff[4]) + CW'(s1_p_ff[5])) <<< 1;
         s2_c_ff[4] <= CW'(s1_p_ff[0]) - CW'(s1_p_ff[1]) + CW'(s1_p_ff[2]) - CW'(s1_p_ff[3]);
         s2_c_ff[5] <= (CW'(s1_p_ff[8]) - CW'(s1_p_ff[9])) <<< 1;
         s2_c_ff[6] <= (CW'(s1_p_ff[6]) - CW'(s1_p_ff[7])) <<< 1;
         s2_c_ff[7] <= (CW'(s1_p_ff[8]) + CW'(s1_p_ff[9])) <<< 1;
         s2_c_ff[8] <= CW'(s1_p_ff[0]) - CW'(s1_p_ff[1]) - CW'(s1_p_ff[2]) + CW'(s1_p_ff[3]);
         s2_d_ff    <= CW'(s1_p_ff[0]) + CW'(s1_p_ff[1]) + CW'(s1_p_ff[2]) + CW'(s1_p_ff[3]);
         // stage 3
         s3_z_ff   <= s2_z_ff;
         s3_vec_ff <= s2_vec_ff;
         s3_d_ff   <= s2_d_ff;
         for (int k = 0; k < 9; k++) begin
            s3_lo_ff[k] <= $signed(s2_vec_ff[k%3]) * $signed({1'b0, s2_c_ff[k][SPLIT-1:0]});
            s3_hi_ff[k] <= $signed(s2_vec_ff[k%3]) * $signed(s2_c_ff[k][CW-1:SPLIT]);
         end
         // stage 4
         s4_z_ff   <= s3_z_ff;
         s4_vec_ff <= s3_vec_ff;
         s4_d_ff   <= s3_d_ff;
         for (int k = 0; k < 9; k++) begin
            s4_p_ff[k] <= (NW'(s3_hi_ff[k]) <<< SPLIT) + NW'(s3_lo_ff[k]);
         end
         // stage 5
         s5_z_ff   <= s4_z_ff;
         s5_vec_ff <= s4_vec_ff;
         s5_d_ff   <= s4_d_ff;
         for (int r = 0; r < 3; r++) begin
            s5_n_ff[r] <= s4_p_ff[3*r] + s4_p_ff[3*r+1] + s4_p_ff[3*r+2];
         end
         // divider set-up
         dv_z_ff[0]   <= s5_z_ff;
         dv_vec_ff[0] <= s5_vec_ff;
         dv_d_ff[0]   <= s5_d_ff;
         for (int r = 0; r < 3; r++) begin
            dv_rem_ff[0][r] <= su_rem_in[r];
            dv_q_ff[0][r]   <= '0;
            dv_neg_ff[0][r] <= s5_n_ff[r][NW-1];
         end
         // divider stages
         for (int j = 1; j <= QB; j++) begin
            dv_z_ff[j]   <= dv_z_ff[j-1];
            dv_vec_ff[j] <= dv_vec_ff[j-1];
            dv_d_ff[j]   <= dv_d_ff[j-1];
            for (int r = 0; r < 3; r++) begin
               dv_rem_ff[j][r] <= dv_rem_in[j][r];
               dv_q_ff[j][r]   <= dv_q_in[j][r];
               dv_neg_ff[j][r] <= dv_neg_ff[j-1][r];
            end
         end
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end
endmodule
`default_nettype wire

FILE: src/qvr_checker.sv
// quaternion vector rotate: port-level checks and their bind to the core
// depends on qvr_pkg
`timescale 1ns / 1ps
`default_nettype none
module qvr_checker
   import qvr_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_tvalid,
   input wire logic            rsp_tready,
   input wire logic [3*DW-1:0] rsp_tdata,
   input wire logic [1:0]      rsp_tuser
);
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("zero_length with saturated");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (rsp_tdata[DW-1:0] == MAXV || rsp_tdata[DW-1:0] == MINV ||
          rsp_tdata[2*DW-1:DW] == MAXV || rsp_tdata[2*DW-1:DW] == MINV ||
          rsp_tdata[3*DW-1:2*DW] == MAXV || rsp_tdata[3*DW-1:2*DW] == MINV))
      else $error("saturated without a clipped component");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled transaction changed");
endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);
`default_nettype wire
